// ===== design/kps_pkg.sv =====
// ----------------------------------------------------------------------------
// kps_pkg
// Shared constants, action codes and beat, command and status types for the
// order-statistic count tree.
// ----------------------------------------------------------------------------
`default_nettype none

package kps_pkg;

  // Tree geometry: a full binary tree over LEAVES slots, heap-indexed from 1.
  localparam int LEAVES = 1024;
  localparam int LEVELS = 10;
  localparam int NODES  = 2 * LEAVES;
  localparam int NODE_W = LEVELS + 1;
  localparam int LVL_W  = 4;

  // Field widths.
  localparam int ACT_W  = 2;
  localparam int RANK_W = 11;
  localparam int SLOT_W = 10;
  localparam int CNT_W  = 11;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_RESTART = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SELECT  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE  = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [RANK_W-1:0] rank;
    logic [SLOT_W-1:0] position;
  } kps_in_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  remaining;
  } kps_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic build;
    logic sel_rd;
    logic sel_step;
    logic rm_rd;
    logic rm_chk;
    logic rm_dec;
    logic emit;
  } kps_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             sel_ok;
    logic             sel_last;
    logic             leaf_present;
    logic             rm_last;
    logic             build_last;
  } kps_status_t;

endpackage

`default_nettype wire

// ===== design/kth_present_select_tree.sv =====
// ----------------------------------------------------------------------------
// kth_present_select_tree
// Order-statistic count tree over 1024 slots with restart, select and remove.
// ----------------------------------------------------------------------------
// An item is taken when start is high while busy is low; busy then stays
// high until the item is done, and its result beat shows on res_o for exactly
// one cycle with res_valid_o high, in the first cycle that busy is low again.
// The receiver cannot hold a result off. A select walks one tree level per
// cycle through the single-read-port count memory, and goes straight to the
// result beat when the rank is zero or above the remaining count. A remove
// first reads the leaf, then lowers one count per level, and lowers none when
// the slot is absent. A restart rewrites all 2047 nodes of the count memory,
// one node per cycle. Until the first restart no slot is present. active_count
// is written through the cfg channel, which is always ready; the user must
// write it only while busy is low, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module kth_present_select_tree (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  kps_pkg::kps_in_t          item_i,
  output logic                      res_valid_o,
  output kps_pkg::kps_out_t         res_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [kps_pkg::CNT_W-1:0] cfg_data_i
);

  kps_pkg::kps_cmd_t    cmd;
  kps_pkg::kps_status_t status;
  logic                 cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  kps_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .status_i    (status),
    .cmd_o       (cmd),
    .busy_o      (busy),
    .res_valid_o (res_valid_o)
  );

  kps_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_i),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .res_o      (res_o)
  );

endmodule

`default_nettype wire

// ===== design/kps_datapath.sv =====
// ----------------------------------------------------------------------------
// kps_datapath
// Count memory, walk registers and result register of the count tree.
// ----------------------------------------------------------------------------
`default_nettype none

module kps_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  kps_pkg::kps_in_t              item_i,
  input  logic                          cfg_we_i,
  input  logic [kps_pkg::CNT_W-1:0]     cfg_data_i,
  input  kps_pkg::kps_cmd_t             cmd_i,
  output kps_pkg::kps_status_t          status_o,
  output kps_pkg::kps_out_t             res_o
);

  localparam int CW = kps_pkg::CNT_W;
  localparam int NW = kps_pkg::NODE_W;
  localparam int LW = kps_pkg::LVL_W;
  localparam int SW = kps_pkg::SLOT_W;
  localparam logic [CW-1:0] LEAVES_C = CW'(kps_pkg::LEAVES);

  logic [CW-1:0] mem [0:kps_pkg::NODES-1];

  logic [CW-1:0] active_q, active_d;
  logic [CW-1:0] k_q, k_d;
  logic [CW-1:0] root_q, root_d;
  logic          built_q, built_d;
  logic [NW-1:0] node_q, node_d;
  logic [LW-1:0] lvl_q, lvl_d;
  logic [CW-1:0] r_q, r_d;
  logic [SW-1:0] pos_q, pos_d;
  logic          found_q, found_d;
  logic [SW-1:0] slot_q, slot_d;
  logic [CW-1:0] rd_q;
  kps_pkg::kps_out_t res_q, res_d;

  logic          rd_en, wr_en;
  logic [NW-1:0] rd_addr, wr_addr;
  logic [CW-1:0] wr_data;
  logic [CW-1:0] rd_val;
  logic [CW-1:0] k_clip;
  logic [LW-1:0] shift;
  logic [NW-1:0] node_ext;
  logic [SW-1:0] lo;
  logic [CW-1:0] size, hi, build_cnt;
  logic [NW-1:0] left_child, sel_node, path_cur, path_nxt, node_inc;
  logic          go_left;

  // Before the first restart the memory holds nothing, and every count is zero.
  assign rd_val = built_q ? rd_q : '0;
  assign k_clip = (active_q > LEAVES_C) ? LEAVES_C : active_q;

  // A node at level L covers 2^(LEVELS-L) slots starting at its index within
  // the level shifted up; the shifted node number carries that start below
  // its top bit.
  assign shift     = LW'(kps_pkg::LEVELS) - lvl_q;
  assign node_ext  = NW'(node_q << shift);
  assign lo        = node_ext[SW-1:0];
  assign size      = CW'(1) << shift;
  assign hi        = CW'(lo) + size;
  assign build_cnt = (hi <= k_q) ? size : ((k_q > CW'(lo)) ? (k_q - CW'(lo)) : '0);
  assign node_inc  = NW'(node_q + 1'b1);

  assign left_child = NW'({node_q, 1'b0});
  assign go_left    = r_q < rd_val;
  assign sel_node   = {node_q[NW-2:0], ~go_left};

  assign path_cur = NW'({1'b1, pos_q} >> shift);
  assign path_nxt = NW'({1'b1, pos_q} >> LW'(shift - 1'b1));

  assign status_o.act          = item_i.action;
  assign status_o.sel_ok       = (item_i.rank != '0) && (item_i.rank <= root_q);
  assign status_o.sel_last     = lvl_q == LW'(kps_pkg::LEVELS - 1);
  assign status_o.leaf_present = rd_val != '0;
  assign status_o.rm_last      = lvl_q == LW'(kps_pkg::LEVELS);
  assign status_o.build_last   = node_q == NW'(kps_pkg::NODES - 1);

  assign res_o = res_q;

  always_comb begin
    active_d = active_q;
    k_d      = k_q;
    root_d   = root_q;
    built_d  = built_q;
    node_d   = node_q;
    lvl_d    = lvl_q;
    r_d      = r_q;
    pos_d    = pos_q;
    found_d  = found_q;
    slot_d   = slot_q;
    res_d    = res_q;
    rd_en    = 1'b0;
    rd_addr  = left_child;
    wr_en    = 1'b0;
    wr_addr  = node_q;
    wr_data  = build_cnt;

    if (cfg_we_i) begin
      active_d = cfg_data_i;
    end

    if (cmd_i.latch) begin
      node_d  = NW'(1);
      lvl_d   = '0;
      r_d     = CW'(item_i.rank - 1'b1);
      pos_d   = item_i.position;
      found_d = 1'b0;
      slot_d  = '0;
      if (item_i.action == kps_pkg::ACT_RESTART) begin
        k_d     = k_clip;
        root_d  = k_clip;
        built_d = 1'b1;
      end
    end

    if (cmd_i.build) begin
      wr_en   = 1'b1;
      wr_addr = node_q;
      wr_data = build_cnt;
      node_d  = node_inc;
      // Crossing into the next level when the node number is all ones.
      if ((node_inc & node_q) == '0) begin
        lvl_d = LW'(lvl_q + 1'b1);
      end
    end

    if (cmd_i.sel_rd) begin
      rd_en   = 1'b1;
      rd_addr = left_child;
    end

    if (cmd_i.sel_step) begin
      node_d = sel_node;
      lvl_d  = LW'(lvl_q + 1'b1);
      if (!go_left) begin
        r_d = r_q - rd_val;
      end
      if (status_o.sel_last) begin
        found_d = 1'b1;
        slot_d  = sel_node[SW-1:0];
      end else begin
        rd_en   = 1'b1;
        rd_addr = NW'({sel_node, 1'b0});
      end
    end

    if (cmd_i.rm_rd) begin
      rd_en   = 1'b1;
      rd_addr = {1'b1, pos_q};
    end

    if (cmd_i.rm_chk) begin
      if (rd_val != '0) begin
        found_d = 1'b1;
        slot_d  = pos_q;
      end
      rd_en   = 1'b1;
      rd_addr = path_cur;
    end

    if (cmd_i.rm_dec) begin
      wr_en   = 1'b1;
      wr_addr = path_cur;
      wr_data = (rd_val != '0) ? CW'(rd_val - 1'b1) : rd_val;
      if (lvl_q == '0 && root_q != '0) begin
        root_d = CW'(root_q - 1'b1);
      end
      lvl_d = LW'(lvl_q + 1'b1);
      if (!status_o.rm_last) begin
        rd_en   = 1'b1;
        rd_addr = path_nxt;
      end
    end

    if (cmd_i.emit) begin
      res_d.found     = found_q;
      res_d.slot      = slot_q;
      res_d.remaining = root_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= LEAVES_C;
      root_q   <= '0;
      built_q  <= 1'b0;
    end else begin
      active_q <= active_d;
      root_q   <= root_d;
      built_q  <= built_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q     <= k_d;
    node_q  <= node_d;
    lvl_q   <= lvl_d;
    r_q     <= r_d;
    pos_q   <= pos_d;
    found_q <= found_d;
    slot_q  <= slot_d;
    res_q   <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // No count is written before a restart has defined the tree.
  a_write_after_build: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> built_q)
    else $error("count memory written before the tree was built");

  // The stored root count agrees with the root register when a remove lowers it.
  a_root_mirror: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.rm_dec && lvl_q == '0) |-> (rd_val == root_q))
    else $error("root count in memory differs from root register");

endmodule

`default_nettype wire

// ===== design/kps_controller.sv =====
// ----------------------------------------------------------------------------
// kps_controller
// Sequencer for restart, select and remove on the count tree.
// ----------------------------------------------------------------------------
`default_nettype none

module kps_controller (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  kps_pkg::kps_status_t status_i,
  output kps_pkg::kps_cmd_t    cmd_o,
  output logic                 busy_o,
  output logic                 res_valid_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_BUILD  = 3'd1;
  localparam logic [2:0] S_SEL_RD = 3'd2;
  localparam logic [2:0] S_SEL    = 3'd3;
  localparam logic [2:0] S_RM_RD  = 3'd4;
  localparam logic [2:0] S_RM_CHK = 3'd5;
  localparam logic [2:0] S_RM_DEC = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state_q, state_d;
  logic       res_valid_q;

  assign busy_o      = state_q != S_IDLE;
  assign res_valid_o = res_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          unique case (status_i.act)
            kps_pkg::ACT_RESTART: state_d = S_BUILD;
            kps_pkg::ACT_SELECT:  state_d = status_i.sel_ok ? S_SEL_RD : S_DONE;
            kps_pkg::ACT_REMOVE:  state_d = S_RM_RD;
            default:              state_d = S_DONE;
          endcase
        end
      end
      S_BUILD: begin
        cmd_o.build = 1'b1;
        if (status_i.build_last) begin
          state_d = S_DONE;
        end
      end
      S_SEL_RD: begin
        cmd_o.sel_rd = 1'b1;
        state_d      = S_SEL;
      end
      S_SEL: begin
        cmd_o.sel_step = 1'b1;
        if (status_i.sel_last) begin
          state_d = S_DONE;
        end
      end
      S_RM_RD: begin
        cmd_o.rm_rd = 1'b1;
        state_d     = S_RM_CHK;
      end
      S_RM_CHK: begin
        cmd_o.rm_chk = 1'b1;
        state_d      = status_i.leaf_present ? S_RM_DEC : S_DONE;
      end
      S_RM_DEC: begin
        cmd_o.rm_dec = 1'b1;
        if (status_i.rm_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        cmd_o.emit = 1'b1;
        state_d    = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= cmd_o.emit;
    end
  end

  // Every result beat stands alone: the strobe is never high in back-to-back cycles.
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |=> !res_valid_q)
    else $error("result strobe held for more than one cycle");

  // A select with an out-of-range rank goes straight to the result.
  a_reject_select: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && start_i && status_i.act == kps_pkg::ACT_SELECT
     && !status_i.sel_ok) |=> (state_q == S_DONE))
    else $error("rejected select did not finish at once");

endmodule

`default_nettype wire
